// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ntc_pkg.sv =====
`default_nettype none
package ntc_pkg;
   localparam int TableEntries = 166;
   localparam int AdcFullScale = 4095;
   localparam logic [17:0] PullupQ4 = 18'd160000;
   localparam logic [28:0] ResMax = 29'h1FFF_FFFF;
   localparam logic [15:0] NoSample = 16'hFFFF;
   localparam logic [15:0] TempFirstQ8 = 16'hD800; // -40 C
   localparam logic [15:0] TempLastQ8 = 16'd32000;  // 125 C
   localparam int IdxW = 8;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_ADC_UPPER = 1'b1;

   // Classified item handed from front to back.
   typedef struct packed {
      logic        sensor_id;
      logic        valid;
      logic [11:0] raw;
   } item_type;

   // Ohms at -40 C + i, one entry per degree.
   localparam int NtcOhms [TableEntries] = '{
      197390, 186540, 176350, 166800, 157820, 149390, 141510, 134090, 127110, 120530,
      114340, 108530, 103040, 97870, 92989, 88381, 84036, 79931, 76052, 72384,
      68915, 65634, 62529, 59589, 56804, 54166, 51665, 49294, 47046, 44913,
      42889, 40967, 39142, 37408, 35761, 34196, 32707, 31291, 29945, 28664,
      27445, 26283, 25177, 24124, 23121, 22165, 21253, 20384, 19555, 18764,
      18010, 17290, 16602, 15946, 15319, 14720, 14148, 13601, 13078, 12578,
      12099, 11642, 11204, 10785, 10384, 10000, 9632, 9280, 8943, 8619,
      8309, 8012, 7727, 7453, 7191, 6939, 6698, 6466, 6243, 6029,
      5824, 5627, 5437, 5255, 5080, 4911, 4749, 4593, 4443, 4299,
      4160, 4027, 3898, 3774, 3654, 3539, 3429, 3322, 3219, 3119,
      3024, 2931, 2842, 2756, 2673, 2593, 2516, 2441, 2369, 2300,
      2233, 2168, 2105, 2044, 1985, 1929, 1874, 1821, 1770, 1720,
      1672, 1626, 1581, 1538, 1496, 1455, 1416, 1377, 1340, 1304,
      1270, 1236, 1204, 1172, 1141, 1112, 1083, 1055, 1028, 1002,
      976, 951, 927, 904, 882, 860, 838, 818, 798, 778,
      759, 741, 723, 706, 689, 673, 657, 641, 626, 612,
      598, 584, 570, 557, 545, 532};

   function automatic logic [17:0] ntc_ohms(input logic [IdxW-1:0] i);
      logic [17:0] r;
      if (int'(i) < TableEntries) r = 18'(NtcOhms[i]);
      else r = 18'(NtcOhms[TableEntries - 1]);
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ntc_front.sv =====
`default_nettype none
// Accepts samples, classifies them, and holds them in a two-entry queue.
module ntc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic              in_sel,
   input  wire logic [15:0]       in_raw,
   input  wire logic [11:0]       upper,
   output logic                   q_valid,
   input  wire logic              q_ready,
   output ntc_pkg::item_type      q_item
);
   ntc_pkg::item_type q_mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop, ok;
   ntc_pkg::item_type item;

   assign ok = (in_raw != ntc_pkg::NoSample) && (in_raw != 16'd0)
             && (in_raw <= {4'd0, upper})
             && (in_raw < 16'(ntc_pkg::AdcFullScale));
   always_comb begin
      item.sensor_id = in_sel;
      item.valid     = ok;
      item.raw       = in_raw[11:0];
   end

   assign in_ready = (count_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (count_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_item = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wr_ptr_ff] <= item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/ntc_back.sv =====
`default_nettype none
`include "assert_macros.svh"
// Serial divide for resistance, linear table search, serial divide for interpolation
// fraction (not at a table end), then an output register; invalid items go straight to it.
module ntc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   output logic                   q_ready,
   input  wire ntc_pkg::item_type q_item,
   input  wire logic [15:0]       threshold,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [1:0]             out_user,
   output logic [47:0]            out_data
);
   localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_SRCH = 3'd2,
                          S_FRAC = 3'd3, S_OUT = 3'd4;
   logic [2:0]  state_ff;
   logic [5:0]  cnt_ff;
   logic        sid_ff, vld_ff;
   logic [29:0] num_ff;     // quotient accumulates in place
   logic [11:0] den_ff;
   logic [11:0] rem_ff;
   logic [28:0] res_ff;
   logic [7:0]  idx_ff;
   logic [21:0] span_ff;
   logic [29:0] fr_ff;      // frac dividend/quotient
   logic [21:0] frem_ff;
   logic [15:0] temp_ff;

   logic [12:0] rtry;
   logic [22:0] ftry;
   logic        rbit, fbit;
   logic [21:0] hi_c, lo_c, first_q4, last_q4;
   logic [28:0] qsat;

   assign q_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign rtry = {rem_ff, num_ff[29]};
   assign rbit = (rtry >= {1'b0, den_ff});
   assign ftry = {frem_ff, fr_ff[29]};
   assign fbit = (ftry >= {1'b0, span_ff});
   assign hi_c = {ntc_pkg::ntc_ohms(idx_ff), 4'd0};
   assign lo_c = {ntc_pkg::ntc_ohms(idx_ff + 8'd1), 4'd0};
   assign first_q4 = {ntc_pkg::ntc_ohms(8'd0), 4'd0};
   assign last_q4 = {ntc_pkg::ntc_ohms(8'(ntc_pkg::TableEntries - 1)), 4'd0};
   assign qsat = (num_ff[29]) ? ntc_pkg::ResMax : num_ff[28:0];

   always_comb begin
      out_user = {vld_ff, sid_ff};
      out_data = '0;
      out_data[28:0]  = vld_ff ? res_ff : 29'd0;
      out_data[44:29] = vld_ff ? temp_ff : 16'd0;
      out_data[45]    = vld_ff && ($signed(temp_ff) > $signed(threshold));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               sid_ff <= q_item.sensor_id;
               vld_ff <= q_item.valid;
               num_ff <= 30'(q_item.raw) * 30'(ntc_pkg::PullupQ4);
               den_ff <= 12'(ntc_pkg::AdcFullScale) - q_item.raw;
               rem_ff <= '0;
               cnt_ff <= 6'd30;
               state_ff <= q_item.valid ? S_DIV : S_OUT;
            end
            S_DIV: begin
               rem_ff <= rbit ? 12'(rtry - {1'b0, den_ff}) : rtry[11:0];
               num_ff <= {num_ff[28:0], rbit};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) state_ff <= S_SRCH;
               idx_ff <= '0;
            end
            S_SRCH: begin
               res_ff <= qsat;
               if (qsat >= {7'd0, first_q4}) begin
                  temp_ff <= ntc_pkg::TempFirstQ8;
                  state_ff <= S_OUT;
               end else if (qsat <= {7'd0, last_q4}) begin
                  temp_ff <= ntc_pkg::TempLastQ8;
                  state_ff <= S_OUT;
               end else if (qsat >= {7'd0, lo_c}) begin
                  span_ff <= hi_c - lo_c;
                  fr_ff   <= {hi_c - 22'(qsat), 8'd0};
                  frem_ff <= '0;
                  cnt_ff  <= 6'd30;
                  state_ff <= S_FRAC;
               end else begin
                  idx_ff <= idx_ff + 8'd1;
               end
            end
            S_FRAC: begin
               frem_ff <= fbit ? 22'(ftry - {1'b0, span_ff}) : ftry[21:0];
               fr_ff <= {fr_ff[28:0], fbit};
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  // quotient is at most 256, so its low 9 bits are enough
                  temp_ff <= ntc_pkg::TempFirstQ8 + {idx_ff, 8'd0}
                             + {7'd0, fr_ff[7:0], fbit};
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLY(a_ready_idle, clock, reset, q_ready, !out_valid, "ready while busy")
   `ASSERT_NEXT(a_hold, clock, reset, out_valid && !out_ready, out_valid, "result dropped")
   `ASSERT_IMPLY(a_inv_zero, clock, reset, out_valid && !out_user[1],
      out_data == 48'd0, "invalid result not zero")
endmodule
`default_nettype wire

// ===== rtl/core/ntc_adc_to_temperature.sv =====
`default_nettype none
// NTC thermistor ADC-to-temperature converter.
// req_ channel: one ADC sample (tdata) and its sensor number (tuser) per
//   transaction. rsp_ channel: one result per sample, in order.
// csr_ channel: index 0 is the over-limit threshold, index 1 the largest
//   accepted ADC count. Write only while no sample is in flight.
// A front stage validates the sample and queues it (two entries); the back
// stage runs a serial resistance divide, a table walk of one entry per
// cycle, and a serial fraction divide.
// An invalid sample skips the divides and the table walk; a resistance
// clamped to a table end ends the walk at entry 0 and skips the fraction
// divide; one interpolated in table entry k walks entries 0 to k. The back
// stage holds one item at a time and takes a new sample only after the
// last result has left rsp_.
// Reset empties the queue, idles the back stage and restores the registers
// to 90 C and 4093. When the receiver stalls, the result holds on rsp_ and
// the queue keeps taking samples until its two entries are full.
module ntc_adc_to_temperature (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // adc_sample
   input  wire logic        req_tuser,   // sensor_select
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // resistance_q4[28:0], temperature_q8[44:29],
                                         // temp_high[45], zero pad
   output logic [1:0]       rsp_tuser,   // sensor_id, reading_valid
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   logic [15:0] thr_ff;
   logic [11:0] upper_ff;
   logic q_valid, q_ready;
   ntc_pkg::item_type q_item;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= 16'd23040;
         upper_ff <= 12'd4093;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ntc_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata;
            ntc_pkg::CSR_ADC_UPPER: upper_ff <= csr_wdata[11:0];
         endcase
      end
   end

   ntc_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_sel(req_tuser), .in_raw(req_tdata),
      .upper(upper_ff),
      .q_valid, .q_ready, .q_item
   );

   ntc_back u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_item,
      .threshold(thr_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_user(rsp_tuser), .out_data(rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

   // one converted reading
   typedef struct packed {
      logic        hot;
      logic [15:0] temperature_q8;
      logic [28:0] resistance_q4;
      logic        reading_valid;
      logic        sensor_id;
   } reading_type;

   // Holds the register copy, predicts readings and checks them in order.
   class scoreboard_type;
      logic signed [15:0] threshold;
      logic [11:0]        adc_upper;
      reading_type        pending[$];
      int                 mismatches;

      function void reset_regs();
         threshold = 16'sd23040;
         adc_upper = 12'd4093;
      endfunction

      function void write_reg(logic idx, logic [15:0] value);
         if (idx == ntc_pkg::CSR_THRESHOLD) threshold = $signed(value);
         else adc_upper = value[11:0];
      endfunction

      function automatic int table_ohms(int i);
         int t[0:165] = '{
            197390, 186540, 176350, 166800, 157820, 149390, 141510, 134090, 127110, 120530,
            114340, 108530, 103040, 97870, 92989, 88381, 84036, 79931, 76052, 72384,
            68915, 65634, 62529, 59589, 56804, 54166, 51665, 49294, 47046, 44913,
            42889, 40967, 39142, 37408, 35761, 34196, 32707, 31291, 29945, 28664,
            27445, 26283, 25177, 24124, 23121, 22165, 21253, 20384, 19555, 18764,
            18010, 17290, 16602, 15946, 15319, 14720, 14148, 13601, 13078, 12578,
            12099, 11642, 11204, 10785, 10384, 10000, 9632, 9280, 8943, 8619,
            8309, 8012, 7727, 7453, 7191, 6939, 6698, 6466, 6243, 6029,
            5824, 5627, 5437, 5255, 5080, 4911, 4749, 4593, 4443, 4299,
            4160, 4027, 3898, 3774, 3654, 3539, 3429, 3322, 3219, 3119,
            3024, 2931, 2842, 2756, 2673, 2593, 2516, 2441, 2369, 2300,
            2233, 2168, 2105, 2044, 1985, 1929, 1874, 1821, 1770, 1720,
            1672, 1626, 1581, 1538, 1496, 1455, 1416, 1377, 1340, 1304,
            1270, 1236, 1204, 1172, 1141, 1112, 1083, 1055, 1028, 1002,
            976, 951, 927, 904, 882, 860, 838, 818, 798, 778,
            759, 741, 723, 706, 689, 673, 657, 641, 626, 612,
            598, 584, 570, 557, 545, 532};
         return t[i];
      endfunction

      function automatic int temp_from_ohms_q4(longint r);
         longint hi, lo;
         if (r >= longint'(table_ohms(0)) * 16) return -10240;
         if (r <= longint'(table_ohms(165)) * 16) return 32000;
         for (int i = 0; i < 165; i++) begin
            hi = longint'(table_ohms(i)) * 16;
            lo = longint'(table_ohms(i + 1)) * 16;
            if (r <= hi && r >= lo)
               return (i - 40) * 256 + int'(((hi - r) * 256) / (hi - lo));
         end
         return 32000;
      endfunction

      function void note_sample(logic sel, logic [15:0] raw);
         reading_type e;
         longint      q;
         int          t;
         e = '0;
         e.sensor_id = sel;
         e.reading_valid = raw != ntc_pkg::NoSample && raw >= 1 && raw <= adc_upper
                           && raw < ntc_pkg::AdcFullScale;
         if (e.reading_valid) begin
            q = (longint'(raw) * 160000) / longint'(ntc_pkg::AdcFullScale - int'(raw));
            if (q > 64'h1FFF_FFFF) q = 64'h1FFF_FFFF;
            e.resistance_q4 = q[28:0];
            t = temp_from_ohms_q4(q);
            e.temperature_q8 = t[15:0];
            e.hot = t > int'(threshold);
         end
         pending.push_back(e);
      endfunction

      function void check_reading(logic [1:0] user, logic [47:0] data);
         reading_type got, exp_r;
         got = '0;
         got.sensor_id = user[0];
         got.reading_valid = user[1];
         got.resistance_q4 = data[28:0];
         got.temperature_q8 = data[44:29];
         got.hot = data[45];
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected reading %h %h", user, data);
            return;
         end
         exp_r = pending.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"reading mismatch: exp id=%0d v=%0d r=%0d t=%0d h=%0d,",
                         " got id=%0d v=%0d r=%0d t=%0d h=%0d"},
                  exp_r.sensor_id, exp_r.reading_valid, exp_r.resistance_q4,
                  $signed(exp_r.temperature_q8), exp_r.hot,
                  got.sensor_id, got.reading_valid, got.resistance_q4,
                  $signed(got.temperature_q8), got.hot);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [15:0] csr_wdata = '0;

   scoreboard_type readings = new();
   int  hold_off_cycles = 0;
   int  cycle_count = 0;
   bit  stall_random = 1;

   ntc_adc_to_temperature i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // cycle limit: covers about 1100 items, worst-case table walks and stalls
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // receiver: long hold-off when requested, otherwise a stall pattern, or always ready with stall_random clear
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready && !reset) readings.check_reading(rsp_tuser, rsp_tdata);
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_tready <= 0;
      end else if (stall_random) begin
         rsp_tready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end else begin
         rsp_tready <= 1;
      end
   end

   task automatic send_sample(logic sel, logic [15:0] raw);
      req_tvalid <= 1;
      req_tdata <= raw;
      req_tuser <= sel;
      do @(posedge clock); while (!req_tready);
      readings.note_sample(sel, raw);
   endtask

   task automatic gap();
      req_tvalid <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (readings.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      readings.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic random_burst(int count);
      int left, burst;
      logic [15:0] raw;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && left > 0) begin
            case ($urandom_range(0, 9))
               0: raw = 16'($urandom());
               1: begin
                  if ($urandom_range(0, 3) == 0) raw = ntc_pkg::NoSample;
                  else raw = 16'($urandom_range(4080, 4095));
               end
               2: raw = 16'($urandom_range(1, 40));
               default: raw = 16'($urandom_range(1, 4094));
            endcase
            send_sample(1'($urandom_range(0, 1)), raw);
            burst--;
            left--;
         end
         if ($urandom_range(0, 3) != 0) gap();
      end
   endtask

   initial begin
      logic [15:0] directed[] = '{16'h0000, 16'hFFFF, 16'd1, 16'd4093, 16'd4094,
         16'd4095, 16'd4096, 16'h8000, 16'h5555, 16'hAAAA, 16'd2047, 16'd200,
         16'd3800, 16'd2700, 16'd1365, 16'd2, 16'd3000};
      repeat (10) @(posedge clock);
      reset <= 0;
      readings.reset_regs();
      @(posedge clock);
      foreach (directed[i]) send_sample(1'(i % 2), directed[i]);
      drain();

      // widest limits: ADC upper 4094 and threshold -40 C; index width is 1 bit
      write_reg(ntc_pkg::CSR_ADC_UPPER, 16'd4094);
      write_reg(ntc_pkg::CSR_THRESHOLD, 16'hD800);
      send_sample(0, 16'd4094);
      send_sample(1, 16'd3000);
      random_burst(200);
      drain();

      write_reg(ntc_pkg::CSR_ADC_UPPER, 16'd1);
      write_reg(ntc_pkg::CSR_THRESHOLD, 16'd32000);
      send_sample(0, 16'd1);
      send_sample(1, 16'd2);
      random_burst(150);
      drain();

      write_reg(ntc_pkg::CSR_ADC_UPPER, 16'hF800);
      write_reg(ntc_pkg::CSR_THRESHOLD, 16'd0);
      random_burst(200);
      drain();

      // long receiver hold-off with the sender still pushing
      write_reg(ntc_pkg::CSR_ADC_UPPER, 16'd4093);
      write_reg(ntc_pkg::CSR_THRESHOLD, 16'd23040);
      hold_off_cycles = 2000;
      random_burst(30);
      random_burst(300);
      drain();

      stall_random = 0;
      write_reg(ntc_pkg::CSR_ADC_UPPER, 16'($urandom_range(1, 4094)));
      write_reg(ntc_pkg::CSR_THRESHOLD, 16'($urandom_range(0, 42240) - 10240));
      random_burst(200);
      drain();

      if (readings.mismatches == 0 && readings.pending.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end
endmodule

`default_nettype wire
